### hdl/ors_pkg.sv
// ----------------------------------------------------------------------------
// ors_pkg: shared types and constants for the 1-Wire ROM search engine
// Holds the opcode and status codes, the transaction payload structs, the
// search state record and the Dallas CRC8 byte update.
// ----------------------------------------------------------------------------
package ors_pkg;

  // Width of a 1-Wire ROM code.
  localparam int unsigned ROM_BITS = 64;

  // Opcodes of an input transaction.
  localparam logic [2:0] OP_FIRST  = 3'd0;
  localparam logic [2:0] OP_NEXT   = 3'd1;
  localparam logic [2:0] OP_VERIFY = 3'd2;
  localparam logic [2:0] OP_BIT    = 3'd3;
  localparam logic [2:0] OP_TARGET = 3'd4;
  localparam logic [2:0] OP_SKIP   = 3'd5;

  // Status codes of a result transaction.
  localparam logic [2:0] ST_CONT  = 3'd0;
  localparam logic [2:0] ST_SEND  = 3'd1;
  localparam logic [2:0] ST_NONE  = 3'd2;
  localparam logic [2:0] ST_FOUND = 3'd3;
  localparam logic [2:0] ST_ACK   = 3'd4;

  // Last bit position inside the family byte.
  localparam logic [6:0] FAMILY_LAST = 7'd8;

  // Reflected polynomial of x^8+x^5+x^4+1.
  localparam logic [7:0] CRC_POLY = 8'h8C;

  typedef struct packed {
    logic [2:0] opcode;
    logic       presence;
    logic       id_bit;
    logic       comp_bit;
    logic [7:0] fam_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic                write_valid;
    logic                write_bit;
    logic                device_found;
    logic                last_device;
    logic [ROM_BITS-1:0] rom_code;
    logic                verify_same;
  } out_item_t;

  // Backup of the discrepancy counters taken by a verify search.
  typedef struct packed {
    logic       last_dev_flag;
    logic [3:0] last_family_disc;
    logic [6:0] last_disc;
  } disc_t;

  typedef struct packed {
    logic [ROM_BITS-1:0] rom_bits;
    logic [6:0]          last_disc;
    logic [3:0]          last_family_disc;
    logic                last_dev_flag;
    logic [6:0]          bit_index;
    logic [6:0]          last_zero_pos;
    logic [7:0]          crc_acc;
    logic                searching;
    logic                verify_mode;
    logic [ROM_BITS-1:0] backup_rom;
    disc_t               backup_disc;
  } state_t;

  // Idle search state: bit index one, everything else zero.
  localparam state_t STATE_RESET = '{bit_index: 7'd1, default: '0};

  // One byte of the Dallas CRC8, LSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/ors_in_stage.sv
// ----------------------------------------------------------------------------
// ors_in_stage: input register of the ROM search engine
// Captures one input transaction and holds it until the step logic consumes
// it. A new transaction is taken in the same cycle the held one moves on.
// ----------------------------------------------------------------------------
module ors_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ors_pkg::in_item_t in_item_i,
  input  logic             advance_i,
  output logic             valid_o,
  output ors_pkg::in_item_t item_o
);

  logic             valid_q;
  ors_pkg::in_item_t item_q;

  // The register is free when empty or when its content moves on this cycle.
  assign in_ready_o = !valid_q || advance_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  // Valid flag of the held transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

### hdl/ors_step.sv
// ----------------------------------------------------------------------------
// ors_step: combinational search step
// Applies one opcode to the search state and forms the result transaction:
// begin handling, one bit pair of the search ROM algorithm, family targeting and
// skipping, and the end-of-search checks on CRC, family byte and verify match.
// ----------------------------------------------------------------------------
module ors_step (
  input  ors_pkg::state_t   state_i,
  input  ors_pkg::in_item_t item_i,
  output ors_pkg::state_t   state_o,
  output ors_pkg::out_item_t result_o
);

  ors_pkg::state_t s;
  logic            fin_req;
  logic            fin_full;
  logic            ok;
  logic            eq;
  logic [5:0]      pos;
  logic            dir;
  logic [2:0]      status;
  logic            wr_valid;
  logic            wr_bit;

  always_comb begin
    s        = state_i;
    fin_req  = 1'b0;
    fin_full = 1'b0;
    ok       = 1'b0;
    eq       = 1'b0;
    pos      = s.bit_index[5:0] - 6'd1;
    dir      = 1'b0;
    status   = ors_pkg::ST_ACK;
    wr_valid = 1'b0;
    wr_bit   = 1'b0;

    // Any opcode other than a bit pair or an unused code abandons a search;
    // an abandoned verify goes back to the saved code and counters.
    if (item_i.opcode == ors_pkg::OP_FIRST || item_i.opcode == ors_pkg::OP_NEXT ||
        item_i.opcode == ors_pkg::OP_VERIFY || item_i.opcode == ors_pkg::OP_TARGET ||
        item_i.opcode == ors_pkg::OP_SKIP) begin
      if (s.searching && s.verify_mode) begin
        s.rom_bits         = s.backup_rom;
        s.last_disc        = s.backup_disc.last_disc;
        s.last_family_disc = s.backup_disc.last_family_disc;
        s.last_dev_flag    = s.backup_disc.last_dev_flag;
      end
      s.searching   = 1'b0;
      s.verify_mode = 1'b0;
    end

    // Opcode specific work.
    unique case (item_i.opcode)
      ors_pkg::OP_FIRST, ors_pkg::OP_NEXT, ors_pkg::OP_VERIFY: begin
        if (item_i.opcode == ors_pkg::OP_FIRST) begin
          s.last_disc        = '0;
          s.last_family_disc = '0;
          s.last_dev_flag    = 1'b0;
        end
        if (item_i.opcode == ors_pkg::OP_VERIFY) begin
          s.backup_rom                   = s.rom_bits;
          s.backup_disc.last_disc        = s.last_disc;
          s.backup_disc.last_family_disc = s.last_family_disc;
          s.backup_disc.last_dev_flag    = s.last_dev_flag;
          s.last_disc                    = 7'(ors_pkg::ROM_BITS);
          s.last_dev_flag                = 1'b0;
          s.verify_mode                  = 1'b1;
        end
        s.bit_index     = 7'd1;
        s.last_zero_pos = '0;
        s.crc_acc       = '0;
        if (s.last_dev_flag || !item_i.presence) begin
          fin_req = 1'b1;
        end else begin
          s.searching = 1'b1;
          status      = ors_pkg::ST_SEND;
        end
      end
      ors_pkg::OP_BIT: begin
        if (s.searching) begin
          if (item_i.id_bit && item_i.comp_bit) begin
            // Nobody answered the slot pair.
            fin_req = 1'b1;
          end else begin
            if (item_i.id_bit != item_i.comp_bit) begin
              dir = item_i.id_bit;
            end else begin
              // Discrepancy: follow the old path, take one at the last
              // discrepancy and zero beyond it.
              if (s.bit_index < s.last_disc) begin
                dir = s.rom_bits[pos];
              end else begin
                dir = (s.bit_index == s.last_disc);
              end
              if (!dir) begin
                s.last_zero_pos = s.bit_index;
                if (s.bit_index <= ors_pkg::FAMILY_LAST) begin
                  s.last_family_disc = s.bit_index[3:0];
                end
              end
            end
            s.rom_bits[pos] = dir;
            wr_valid        = 1'b1;
            wr_bit          = dir;
            // Fold each completed byte into the CRC.
            if (s.bit_index[2:0] == 3'd0) begin
              s.crc_acc = ors_pkg::crc8_byte(s.crc_acc, s.rom_bits[pos[5:3]*8 +: 8]);
            end
            s.bit_index = s.bit_index + 7'd1;
            if (s.bit_index > 7'(ors_pkg::ROM_BITS)) begin
              fin_req  = 1'b1;
              fin_full = 1'b1;
            end else begin
              status = ors_pkg::ST_CONT;
            end
          end
        end
      end
      ors_pkg::OP_TARGET: begin
        s.rom_bits         = ors_pkg::ROM_BITS'(item_i.fam_byte);
        s.last_disc        = 7'(ors_pkg::ROM_BITS);
        s.last_family_disc = '0;
        s.last_dev_flag    = 1'b0;
      end
      ors_pkg::OP_SKIP: begin
        s.last_disc        = {3'd0, s.last_family_disc};
        s.last_family_disc = '0;
        if (s.last_disc == 7'd0) begin
          s.last_dev_flag = 1'b1;
        end
      end
      default: begin
        // Unused opcodes are acknowledged and change nothing.
      end
    endcase

    // End of a search: check CRC and family byte, settle the counters; a verify also compares and restores its backup.
    if (fin_req) begin
      s.searching = 1'b0;
      if (fin_full && s.crc_acc == 8'd0) begin
        s.last_disc = s.last_zero_pos;
        if (s.last_zero_pos == 7'd0) begin
          s.last_dev_flag = 1'b1;
        end
        ok = 1'b1;
      end
      if (!ok || s.rom_bits[7:0] == 8'd0) begin
        s.last_disc        = '0;
        s.last_family_disc = '0;
        s.last_dev_flag    = 1'b0;
        ok                 = 1'b0;
      end
      if (s.verify_mode) begin
        eq                 = ok && (s.rom_bits == s.backup_rom);
        s.rom_bits         = s.backup_rom;
        s.last_disc        = s.backup_disc.last_disc;
        s.last_family_disc = s.backup_disc.last_family_disc;
        s.last_dev_flag    = s.backup_disc.last_dev_flag;
        s.verify_mode      = 1'b0;
      end
      status = ok ? ors_pkg::ST_FOUND : ors_pkg::ST_NONE;
    end
  end

  assign state_o               = s;
  assign result_o.status       = status;
  assign result_o.write_valid  = wr_valid;
  assign result_o.write_bit    = wr_bit;
  assign result_o.device_found = ok;
  assign result_o.last_device  = s.last_dev_flag;
  assign result_o.rom_code     = s.rom_bits;
  assign result_o.verify_same  = eq;

endmodule

### hdl/onewire_rom_search.sv
// Path: input register, then combinational search step, then result register.
// Throughput: one transaction per cycle unless the consumer stalls; the per-bit
// state update is one combinational step between input and result registers.
// Reset (rst_ni low, asynchronous): all search state returns to its idle
// values (bit index one, everything else zero) and both registers empty.
// ----------------------------------------------------------------------------
// onewire_rom_search: 1-Wire search ROM engine, one bit pair per transaction
// Input register, combinational search step with the state registers, and a
// result register that holds a result while the consumer stalls.
// ----------------------------------------------------------------------------
module onewire_rom_search (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ors_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ors_pkg::out_item_t out_item_o
);

  logic               stage_valid;
  ors_pkg::in_item_t  stage_item;
  logic               advance;
  ors_pkg::state_t    state_q;
  ors_pkg::state_t    state_d;
  ors_pkg::out_item_t result;
  logic               out_valid_q;
  ors_pkg::out_item_t out_item_q;

  // The held transaction moves on when the result register is free.
  assign advance = stage_valid && (!out_valid_q || out_ready_i);

  ors_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  ors_step u_step (
    .state_i  (state_q),
    .item_i   (stage_item),
    .state_o  (state_d),
    .result_o (result)
  );

  // Search state, updated once per processed transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ors_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= advance;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### hdl/ors_checker.sv
// ----------------------------------------------------------------------------
// ors_checker: port level checks for the ROM search engine
// Watches the result channel for handshake stability and for consistency
// between the status code and the flag fields of each result transaction.
// ----------------------------------------------------------------------------
module ors_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ors_pkg::out_item_t out_item_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A bus write only happens on a bit-pair step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.write_valid |->
      out_item_o.status == ors_pkg::ST_CONT || out_item_o.status == ors_pkg::ST_FOUND ||
      out_item_o.status == ors_pkg::ST_NONE)
    else $error("write requested outside a bit-pair step");

  // The found flag and the found status go together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.device_found == (out_item_o.status == ors_pkg::ST_FOUND))
    else $error("device_found disagrees with status");

  // A verify match implies a found device.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.verify_same |-> out_item_o.device_found)
    else $error("verify match without a found device");

  // A direction bit of one is only reported when it is written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.write_bit |-> out_item_o.write_valid)
    else $error("write bit set without a write");

endmodule

bind onewire_rom_search ors_checker u_ors_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
